FILE: hw/rtl/cce_pkg.sv
package cce_pkg;

	localparam int MAX_SITES_DEF = 256;
	localparam int SPIN_W        = 16;
	localparam int CPL_W         = 32;
	localparam int TERM_W        = 64;
	localparam int ENERGY_W      = 64;
	localparam int LEN_CFG_W     = 9;
	localparam int OP_W          = 2;
	localparam int SITE_W        = 8;
	localparam int OUT_SHIFT     = 17;

	localparam logic [LEN_CFG_W-1:0] LEN_RESET = 9'd256;

	localparam logic [OP_W-1:0] OP_SPIN   = 2'd0;
	localparam logic [OP_W-1:0] OP_CPL    = 2'd1;
	localparam logic [OP_W-1:0] OP_ENERGY = 2'd2;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_COPY  = 6'b000010,
		S_ADV   = 6'b000100,
		S_RUN   = 6'b001000,
		S_DRAIN = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	typedef struct packed {
		logic rot_a;
		logic rot_b;
		logic copy_b;
	} cell_ctl_t;

	typedef struct packed {
		logic cpl_we;
		logic rd_en;
		logic prod_en;
		logic clear;
	} mac_ctl_t;

endpackage

FILE: hw/rtl/cce_cell.sv
module cce_cell (
	input  logic                              clk,
	input  cce_pkg::cell_ctl_t                ctl,
	input  logic                              act,
	input  logic                              wr,
	input  logic signed [cce_pkg::SPIN_W-1:0] wr_data,
	input  logic signed [cce_pkg::SPIN_W-1:0] a_in,
	input  logic signed [cce_pkg::SPIN_W-1:0] b_in,
	output logic signed [cce_pkg::SPIN_W-1:0] spin_a,
	output logic signed [cce_pkg::SPIN_W-1:0] spin_b
);

	logic signed [cce_pkg::SPIN_W-1:0] a_q;
	logic signed [cce_pkg::SPIN_W-1:0] b_q;

	// The first copy holds the written spin and shifts during a run; the second copy is loaded from it and shifted.
	always_ff @(posedge clk) begin
		if (wr) begin
			a_q <= wr_data;
		end else if (ctl.rot_a && act) begin
			a_q <= a_in;
		end
		if (ctl.copy_b) begin
			b_q <= a_q;
		end else if (ctl.rot_b && act) begin
			b_q <= b_in;
		end
	end

	assign spin_a = a_q;
	assign spin_b = b_q;

endmodule

FILE: hw/rtl/cce_mac.sv
module cce_mac #(
	parameter int MAX_SITES = cce_pkg::MAX_SITES_DEF,
	localparam int IDX_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1,
	localparam int ACC_W = 63 + 2 * IDX_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cce_pkg::mac_ctl_t                 ctl,
	input  logic [IDX_W-1:0]                  wr_addr,
	input  logic signed [cce_pkg::CPL_W-1:0]  wr_data,
	input  logic [IDX_W-1:0]                  rd_addr,
	input  logic signed [cce_pkg::SPIN_W-1:0] spin_a,
	input  logic signed [cce_pkg::SPIN_W-1:0] spin_b,
	output logic signed [ACC_W-1:0]           acc,
	output logic                              pipe_busy
);

	localparam int PAIR_W = 2 * cce_pkg::SPIN_W;
	localparam int PROD_W = cce_pkg::TERM_W;

	logic signed [cce_pkg::CPL_W-1:0]    cpl_mem [MAX_SITES];
	logic signed [cce_pkg::CPL_W-1:0]    cpl_q;
	logic signed [2*cce_pkg::SPIN_W-1:0] pair_s1;
	logic signed [cce_pkg::CPL_W-1:0]    cpl_s1;
	logic signed [cce_pkg::TERM_W-1:0]   term_s2;
	logic                                v_s1;
	logic                                v_s2;
	logic signed [ACC_W-1:0]             acc_q;

	always_ff @(posedge clk) begin
		if (ctl.cpl_we) begin
			cpl_mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			cpl_q <= cpl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		pair_s1 <= PAIR_W'(spin_a) * PAIR_W'(spin_b);
		cpl_s1  <= cpl_q;
		term_s2 <= PROD_W'(pair_s1) * PROD_W'(cpl_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= ctl.prod_en;
			v_s2 <= v_s1;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + {{(ACC_W-cce_pkg::TERM_W){term_s2[cce_pkg::TERM_W-1]}}, term_s2};
			end
		end
	end

	assign acc       = acc_q;
	assign pipe_busy = v_s1 | v_s2;

endmodule

FILE: hw/rtl/circular_coupling_energy.sv
// Channel     | Handshake           | Payload
// ------------+---------------------+--------------------------------------------------
// command     | start, busy         | op, site_index, spin_value, coupling_value
// result      | done (strobe)       | energy, saturated
// config      | cfg_valid/cfg_ready | cfg_data (active_length)
//
// A spin or coupling load gives no result.
// An energy command keeps busy high through the computation for L active sites, with a zero
// result when L < 2, and done marks the result in the cycle that follows;
// the spin ring shifts once a cycle during a pass and feeds one multiply-accumulate chain.
// Reset clears the control state and the accumulator; the stores hold nothing until written.
// busy stays high through a computation, and done marks each result for one cycle.
module circular_coupling_energy #(
	parameter int MAX_SITES = cce_pkg::MAX_SITES_DEF,
	localparam int IDX_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1,
	localparam int LEN_W = $clog2(MAX_SITES + 1),
	localparam int ACC_W = 63 + 2 * IDX_W,
	localparam int CMP_W = (LEN_W > cce_pkg::LEN_CFG_W) ? LEN_W : cce_pkg::LEN_CFG_W,
	localparam int SCMP_W = (IDX_W + 1 > cce_pkg::SITE_W) ? IDX_W + 1 : cce_pkg::SITE_W
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [cce_pkg::OP_W-1:0]             op,
	input  logic [cce_pkg::SITE_W-1:0]           site_index,
	input  logic signed [cce_pkg::SPIN_W-1:0]    spin_value,
	input  logic signed [cce_pkg::CPL_W-1:0]     coupling_value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cce_pkg::LEN_CFG_W-1:0]        cfg_data,
	output logic                                 done,
	output logic signed [cce_pkg::ENERGY_W-1:0]  energy,
	output logic                                 saturated
);

	cce_pkg::state_t                   state_q;
	logic [cce_pkg::LEN_CFG_W-1:0]     active_length_q;
	logic [IDX_W-1:0]                  x_q;
	logic [IDX_W-1:0]                  cnt_q;
	logic                              done_q;
	logic signed [cce_pkg::ENERGY_W-1:0] energy_q;
	logic                              saturated_q;

	logic [LEN_W-1:0]                  len;
	logic [LEN_W-1:0]                  len_m1;
	logic                              accept;
	logic                              wr_ok;
	logic                              spin_we;
	logic [IDX_W-1:0]                  wr_addr;
	logic                              pass_end;
	logic                              last_pass;
	cce_pkg::cell_ctl_t                cell_ctl;
	cce_pkg::mac_ctl_t                 mac_ctl;
	logic signed [ACC_W-1:0]           acc;
	logic                              pipe_busy;
	logic                              fits;
	logic signed [cce_pkg::ENERGY_W-1:0] clamped;

	logic signed [cce_pkg::SPIN_W-1:0] a_row [MAX_SITES];
	logic signed [cce_pkg::SPIN_W-1:0] b_row [MAX_SITES];

	assign len = (CMP_W'(active_length_q) > CMP_W'(MAX_SITES)) ? LEN_W'(MAX_SITES)
	                                                            : LEN_W'(active_length_q);
	assign len_m1    = len - LEN_W'(1);
	assign busy      = (state_q != cce_pkg::S_IDLE);
	assign cfg_ready = ~busy;
	assign accept    = start && !busy;
	assign wr_ok     = SCMP_W'(site_index) < SCMP_W'(MAX_SITES);
	assign wr_addr   = IDX_W'(site_index);
	assign spin_we   = accept && (op == cce_pkg::OP_SPIN) && wr_ok;
	assign pass_end  = (LEN_W'(cnt_q) == len_m1);
	assign last_pass = (LEN_W'(x_q) == len_m1);

	always_comb begin
		cell_ctl.rot_a  = (state_q == cce_pkg::S_RUN);
		cell_ctl.rot_b  = (state_q == cce_pkg::S_RUN) || (state_q == cce_pkg::S_ADV);
		cell_ctl.copy_b = (state_q == cce_pkg::S_COPY);
		mac_ctl.cpl_we  = accept && (op == cce_pkg::OP_CPL) && wr_ok;
		mac_ctl.rd_en   = (state_q == cce_pkg::S_ADV);
		mac_ctl.prod_en = (state_q == cce_pkg::S_RUN);
		mac_ctl.clear   = accept && (op == cce_pkg::OP_ENERGY);
	end

	for (genvar k = 0; k < MAX_SITES; k++) begin : g_ring
		localparam int NXT = (k + 1) % MAX_SITES;
		logic act;
		logic wrap;
		assign act  = LEN_W'(k) < len;
		assign wrap = LEN_W'(k + 1) == len;
		cce_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl),
			.act     (act),
			.wr      (spin_we && (wr_addr == IDX_W'(k))),
			.wr_data (spin_value),
			.a_in    (wrap ? a_row[0] : a_row[NXT]),
			.b_in    (wrap ? b_row[0] : b_row[NXT]),
			.spin_a  (a_row[k]),
			.spin_b  (b_row[k])
		);
	end

	cce_mac #(
		.MAX_SITES (MAX_SITES)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.wr_addr   (wr_addr),
		.wr_data   (coupling_value),
		.rd_addr   (x_q),
		.spin_a    (a_row[0]),
		.spin_b    (b_row[0]),
		.acc       (acc),
		.pipe_busy (pipe_busy)
	);

	assign fits = (&acc[ACC_W-1:cce_pkg::ENERGY_W-1]) || !(|acc[ACC_W-1:cce_pkg::ENERGY_W-1]);

	always_comb begin
		if (fits) begin
			clamped = acc[cce_pkg::ENERGY_W-1:0];
		end else if (acc[ACC_W-1]) begin
			clamped = {1'b1, {(cce_pkg::ENERGY_W-1){1'b0}}};
		end else begin
			clamped = {1'b0, {(cce_pkg::ENERGY_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= cce_pkg::S_IDLE;
			active_length_q <= cce_pkg::LEN_RESET;
			x_q             <= '0;
			cnt_q           <= '0;
			done_q          <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				active_length_q <= cfg_data;
			end
			unique case (state_q)
				cce_pkg::S_IDLE: begin
					if (accept && (op == cce_pkg::OP_ENERGY)) begin
						state_q <= (len < LEN_W'(2)) ? cce_pkg::S_DRAIN : cce_pkg::S_COPY;
					end
				end
				cce_pkg::S_COPY: begin
					x_q     <= IDX_W'(1);
					state_q <= cce_pkg::S_ADV;
				end
				cce_pkg::S_ADV: begin
					cnt_q   <= '0;
					state_q <= cce_pkg::S_RUN;
				end
				cce_pkg::S_RUN: begin
					if (pass_end) begin
						if (last_pass) begin
							state_q <= cce_pkg::S_DRAIN;
						end else begin
							x_q     <= x_q + IDX_W'(1);
							state_q <= cce_pkg::S_ADV;
						end
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				cce_pkg::S_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= cce_pkg::S_FIN;
					end
				end
				cce_pkg::S_FIN: begin
					done_q  <= 1'b1;
					state_q <= cce_pkg::S_IDLE;
				end
				default: begin
					state_q <= cce_pkg::S_IDLE;
				end
			endcase
		end
	end

	// The result is the clamped sum shifted right, rounding towards minus infinity.
	always_ff @(posedge clk) begin
		if (state_q == cce_pkg::S_FIN) begin
			energy_q    <= {{cce_pkg::OUT_SHIFT{clamped[cce_pkg::ENERGY_W-1]}},
			                clamped[cce_pkg::ENERGY_W-1:cce_pkg::OUT_SHIFT]};
			saturated_q <= !fits;
		end
	end

	assign done      = done_q;
	assign energy    = energy_q;
	assign saturated = saturated_q;

endmodule

FILE: tb/testbench.sv
module testbench;

	localparam logic [cce_pkg::OP_W-1:0] OP_NONE = 2'd3;
	localparam int SITES = cce_pkg::MAX_SITES_DEF;
	localparam int SPIN_BITS = cce_pkg::SPIN_W;
	localparam int SITE_BITS = cce_pkg::SITE_W;
	localparam int LEN_BITS = cce_pkg::LEN_CFG_W;
	localparam int TARGET_ITEMS = 1150;
	localparam int NUM_ROWS = 29;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic signed [cce_pkg::ENERGY_W-1:0] energy;
		logic                                sat;
	} energy_res_t;

	typedef enum logic {ROW_LEN, ROW_CMD} row_kind_t;

	typedef struct packed {
		row_kind_t                           kind;
		logic [cce_pkg::OP_W-1:0]            op;
		logic [cce_pkg::SITE_W-1:0]          idx;
		logic signed [cce_pkg::SPIN_W-1:0]   spin;
		logic signed [cce_pkg::CPL_W-1:0]    cpl;
		logic [cce_pkg::LEN_CFG_W-1:0]       len;
		logic                                typed;
		logic signed [cce_pkg::ENERGY_W-1:0] energy;
		logic                                sat;
	} dir_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic [cce_pkg::OP_W-1:0]            op;
	logic [cce_pkg::SITE_W-1:0]          site_index;
	logic signed [cce_pkg::SPIN_W-1:0]   spin_value;
	logic signed [cce_pkg::CPL_W-1:0]    coupling_value;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [cce_pkg::LEN_CFG_W-1:0]       cfg_data;
	logic                                done;
	logic signed [cce_pkg::ENERGY_W-1:0] energy;
	logic                                saturated;

	logic signed [cce_pkg::SPIN_W-1:0] spin_mem [SITES];
	logic signed [cce_pkg::CPL_W-1:0]  cpl_mem [SITES];
	bit                                spin_written [SITES];
	bit                                cpl_written [SITES];
	logic [cce_pkg::LEN_CFG_W-1:0]     ring_len = cce_pkg::LEN_RESET;

	energy_res_t pending_energy [$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	dir_row_t    dir_rows [NUM_ROWS];

	circular_coupling_energy DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.site_index    (site_index),
		.spin_value    (spin_value),
		.coupling_value(coupling_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.energy        (energy),
		.saturated     (saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#200000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic energy_res_t ring_energy();
		energy_res_t                         res;
		logic signed [127:0]                 total;
		logic signed [31:0]                  pair;
		logic signed [63:0]                  term;
		logic signed [cce_pkg::ENERGY_W-1:0] acc;
		int                                  len;
		int                                  j;
		len = (ring_len > SITES) ? SITES : int'(ring_len);
		total = '0;
		for (int i = 0; i < len; i++) begin
			for (int x = 1; x < len; x++) begin
				j = (i + x) % len;
				pair = spin_mem[i] * spin_mem[j];
				term = pair * cpl_mem[x];
				total = total + term;
			end
		end
		res.sat = 1'b0;
		if (total > 128'sh7FFF_FFFF_FFFF_FFFF) begin
			acc = 64'sh7FFF_FFFF_FFFF_FFFF;
			res.sat = 1'b1;
		end else if (total < -128'sh8000_0000_0000_0000) begin
			acc = 64'sh8000_0000_0000_0000;
			res.sat = 1'b1;
		end else begin
			acc = total[63:0];
		end
		res.energy = acc >>> cce_pkg::OUT_SHIFT;
		return res;
	endfunction

	function automatic logic signed [cce_pkg::SPIN_W-1:0] rand_spin();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return SPIN_BITS'($urandom());
		endcase
	endfunction

	function automatic logic signed [cce_pkg::CPL_W-1:0] rand_cpl();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh0000_0000;
			3: return 32'sh0001_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic dir_row_t row_len(input logic [cce_pkg::LEN_CFG_W-1:0] v);
		dir_row_t r;
		r = '0;
		r.kind = ROW_LEN;
		r.len = v;
		return r;
	endfunction

	function automatic dir_row_t row_cmd(input logic [cce_pkg::OP_W-1:0] c_op,
			input logic [cce_pkg::SITE_W-1:0] c_idx,
			input logic signed [cce_pkg::SPIN_W-1:0] c_spin,
			input logic signed [cce_pkg::CPL_W-1:0] c_cpl);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CMD;
		r.op = c_op;
		r.idx = c_idx;
		r.spin = c_spin;
		r.cpl = c_cpl;
		return r;
	endfunction

	function automatic dir_row_t row_check(input logic signed [cce_pkg::ENERGY_W-1:0] e,
			input logic s);
		dir_row_t r;
		r = row_cmd(cce_pkg::OP_ENERGY, '0, '0, '0);
		r.typed = 1'b1;
		r.energy = e;
		r.sat = s;
		return r;
	endfunction

	task automatic send_item(input logic [cce_pkg::OP_W-1:0] c_op,
			input logic [cce_pkg::SITE_W-1:0] c_idx,
			input logic signed [cce_pkg::SPIN_W-1:0] c_spin,
			input logic signed [cce_pkg::CPL_W-1:0] c_cpl,
			input logic typed = 1'b0,
			input logic signed [cce_pkg::ENERGY_W-1:0] t_energy = '0,
			input logic t_sat = 1'b0);
		energy_res_t res;
		start <= 1'b1;
		op <= c_op;
		site_index <= c_idx;
		spin_value <= c_spin;
		coupling_value <= c_cpl;
		do @(posedge clk); while (busy);
		case (c_op)
			cce_pkg::OP_SPIN: begin
				spin_mem[c_idx] = c_spin;
				spin_written[c_idx] = 1'b1;
			end
			cce_pkg::OP_CPL: begin
				cpl_mem[c_idx] = c_cpl;
				cpl_written[c_idx] = 1'b1;
			end
			cce_pkg::OP_ENERGY: begin
				if (typed) begin
					res.energy = t_energy;
					res.sat = t_sat;
				end else begin
					res = ring_energy();
				end
				pending_energy.push_back(res);
			end
			default: ;
		endcase
		if (c_op != OP_NONE)
			items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic set_ring_len(input logic [cce_pkg::LEN_CFG_W-1:0] v);
		start <= 1'b0;
		while (pending_energy.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ring_len = v;
	endtask

	task automatic ensure_loaded(input int len);
		int eff;
		eff = (len > SITES) ? SITES : len;
		for (int k = 0; k < eff; k++) begin
			if (!spin_written[k])
				send_item(cce_pkg::OP_SPIN, SITE_BITS'(k), rand_spin(), rand_cpl());
			if (k > 0 && !cpl_written[k])
				send_item(cce_pkg::OP_CPL, SITE_BITS'(k), rand_spin(), rand_cpl());
		end
	endtask

	always @(posedge clk) begin
		energy_res_t want;
		if (arst_n && done) begin
			if (pending_energy.size() == 0) begin
				$display("%0t: unexpected result, energy %0d saturated %0b", $time, energy,
					saturated);
				mismatches++;
			end else begin
				want = pending_energy.pop_front();
				if (energy !== want.energy) begin
					$display("%0t: energy expected %0d, got %0d", $time, want.energy, energy);
					mismatches++;
				end
				if (saturated !== want.sat) begin
					$display("%0t: saturated expected %0b, got %0b", $time, want.sat, saturated);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int  r;
		int  len;
		int  span;
		bit  did_full;
		bit  did_over;
		bit  big;
		did_full = 1'b0;
		did_over = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		op = cce_pkg::OP_SPIN;
		site_index = '0;
		spin_value = '0;
		coupling_value = '0;
		cfg_valid = 1'b0;
		cfg_data = cce_pkg::LEN_RESET;

		dir_rows = '{
			row_len(9'd2),
			row_cmd(cce_pkg::OP_SPIN, 8'd0, 16'sd1, 32'sd0),
			row_cmd(cce_pkg::OP_SPIN, 8'd1, 16'sd1, 32'sd0),
			row_cmd(cce_pkg::OP_CPL, 8'd1, 16'sd0, 32'sh0001_0000),
			row_cmd(cce_pkg::OP_CPL, 8'd0, 16'sd0, 32'sh7FFF_FFFF),
			row_check(64'sd1, 1'b0),
			row_cmd(OP_NONE, 8'hFF, 16'shFFFF, 32'shFFFF_FFFF),
			row_cmd(cce_pkg::OP_SPIN, 8'd0, 16'sh8000, 32'sd0),
			row_cmd(cce_pkg::OP_SPIN, 8'd1, 16'sh8000, 32'sd0),
			row_cmd(cce_pkg::OP_CPL, 8'd1, 16'sd0, 32'sh8000_0000),
			row_check(64'shFFFF_E000_0000_0000, 1'b0),
			row_len(9'd4),
			row_cmd(cce_pkg::OP_SPIN, 8'd2, 16'sh8000, 32'sd0),
			row_cmd(cce_pkg::OP_SPIN, 8'd3, 16'sh8000, 32'sd0),
			row_cmd(cce_pkg::OP_CPL, 8'd2, 16'sd0, 32'sh8000_0000),
			row_cmd(cce_pkg::OP_CPL, 8'd3, 16'sd0, 32'sh8000_0000),
			row_check(64'shFFFF_C000_0000_0000, 1'b1),
			row_cmd(cce_pkg::OP_CPL, 8'd1, 16'sd0, 32'sh7FFF_FFFF),
			row_cmd(cce_pkg::OP_CPL, 8'd2, 16'sd0, 32'sh7FFF_FFFF),
			row_cmd(cce_pkg::OP_CPL, 8'd3, 16'sd0, 32'sh7FFF_FFFF),
			row_check(64'sh0000_3FFF_FFFF_FFFF, 1'b1),
			row_cmd(cce_pkg::OP_SPIN, 8'd255, 16'sh7FFF, 32'sd0),
			row_cmd(cce_pkg::OP_SPIN, 8'd1, 16'sd12345, 32'sd0),
			row_len(9'd3),
			row_cmd(cce_pkg::OP_ENERGY, 8'd0, 16'sd0, 32'sd0),
			row_len(9'd0),
			row_check(64'sd0, 1'b0),
			row_len(9'd1),
			row_check(64'sd0, 1'b0)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_LEN)
				set_ring_len(dir_rows[i].len);
			else
				send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].spin, dir_rows[i].cpl,
					dir_rows[i].typed, dir_rows[i].energy, dir_rows[i].sat);
		end

		while (items_sent < TARGET_ITEMS || !did_over) begin
			big = 1'b1;
			if (!did_full && items_sent >= 600) begin
				len = SITES;
				did_full = 1'b1;
			end else if (!did_over && items_sent >= 1000) begin
				len = (1 << cce_pkg::LEN_CFG_W) - 1;
				did_over = 1'b1;
			end else begin
				big = 1'b0;
				r = $urandom_range(0, 99);
				if (r < 5)
					len = $urandom_range(0, 1);
				else if (r < 70)
					len = $urandom_range(2, 12);
				else if (r < 92)
					len = $urandom_range(13, 32);
				else
					len = $urandom_range(33, 64);
			end
			set_ring_len(LEN_BITS'(len));
			span = (len > 1) ? ((len > SITES) ? SITES : len) : SITES;

			if (big) begin
				repeat ($urandom_range(3, 10))
					send_item(($urandom_range(0, 1) != 0) ? cce_pkg::OP_SPIN : cce_pkg::OP_CPL,
						SITE_BITS'($urandom_range(0, SITES - 1)), rand_spin(), rand_cpl());
				ensure_loaded(len);
				send_item(cce_pkg::OP_ENERGY, SITE_BITS'($urandom()), rand_spin(), rand_cpl());
			end else begin
				repeat ($urandom_range(15, 50)) begin
					r = $urandom_range(0, 99);
					if (r < 55) begin
						send_item(($urandom_range(0, 1) != 0) ? cce_pkg::OP_SPIN
							: cce_pkg::OP_CPL,
							SITE_BITS'($urandom_range(0, span - 1)), rand_spin(), rand_cpl());
					end else if (r < 75) begin
						send_item(($urandom_range(0, 1) != 0) ? cce_pkg::OP_SPIN
							: cce_pkg::OP_CPL,
							SITE_BITS'($urandom_range(0, SITES - 1)), rand_spin(), rand_cpl());
					end else if (r < 82) begin
						send_item(OP_NONE, SITE_BITS'($urandom()), rand_spin(), rand_cpl());
					end else begin
						ensure_loaded(len);
						send_item(cce_pkg::OP_ENERGY, SITE_BITS'($urandom()), rand_spin(),
							rand_cpl());
					end
				end
			end
		end

		start <= 1'b0;
		while (pending_energy.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: circular_coupling_energy.f
hw/rtl/cce_pkg.sv
hw/rtl/cce_cell.sv
hw/rtl/cce_mac.sv
hw/rtl/circular_coupling_energy.sv
tb/testbench.sv
